>>> hw/rtl/gplr_pkg.sv
// shared constants, types and helpers for the ghost point line reflection block
package gplr_pkg;

    localparam int SQRT_LAT = 33;
    localparam int DIV_LAT  = 31;
    localparam int LINE_LEN = SQRT_LAT + 1 + DIV_LAT;

    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;
    localparam int NUM_W  = 63;
    localparam int QUO_W  = 31;

    typedef struct packed {
        logic               valid;
        logic               deg;
        logic               sx;
        logic               sy;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -42'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/gplr_sqrt.sv
// pipelined integer square root, one root bit per stage
module gplr_sqrt
    import gplr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  rad_reg  [0:SQRT_LAT-1];
    logic [35:0]       rem_reg  [0:SQRT_LAT-1];
    logic [ROOT_W-1:0] root_reg [0:SQRT_LAT-1];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_stage
            logic [RAD_W-1:0]  rad_in;
            logic [35:0]       rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [35:0]       rem_t;
            logic [35:0]       trial;
            logic              fit;
            if (k == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end
            assign rem_t = {rem_in[33:0], rad_in[RAD_W-1 -: 2]};
            assign trial = {1'b0, root_in, 2'b01};
            assign fit   = rem_t >= trial;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                    rem_reg[k]  <= fit ? rem_t - trial : rem_t;
                    root_reg[k] <= {root_in[ROOT_W-2:0], fit};
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_LAT-1];

endmodule

>>> hw/rtl/gplr_div.sv
// pipelined restoring divider, one quotient bit per stage
module gplr_div
    import gplr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [QUO_W-1:0]  quo
);

    logic [63:0]       rem_reg [0:DIV_LAT-1];
    logic [ROOT_W-1:0] den_reg [0:DIV_LAT-1];
    logic [QUO_W-1:0]  quo_reg [0:DIV_LAT-1];

    genvar j;
    generate
        for (j = 0; j < DIV_LAT; j++) begin : g_stage
            logic [63:0]       rem_in;
            logic [ROOT_W-1:0] den_in;
            logic [QUO_W-1:0]  quo_in;
            logic [63:0]       sub;
            logic              fit;
            if (j == 0) begin : g_first
                assign rem_in = {1'b0, num};
                assign den_in = den;
                assign quo_in = '0;
            end
            else begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign den_in = den_reg[j-1];
                assign quo_in = quo_reg[j-1];
            end
            assign sub = {31'b0, den_in} << (DIV_LAT - 1 - j);
            assign fit = rem_in >= sub;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= fit ? rem_in - sub : rem_in;
                    den_reg[j] <= den_in;
                    quo_reg[j] <= {quo_in[QUO_W-2:0], fit};
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_LAT-1];

endmodule

>>> hw/rtl/ghost_point_line_reflection.sv
// top level: segment normal, foot point and mirror of a ghost cell centre
//
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | first_x/y, second_x/y, centre_x/y
//  out     | out_valid/out_ready| foot_x/y, mirror_x/y, normal_x/y, degenerate
//
// a word enters every cycle unless a held output word stalls it; the path runs through
// the 33-stage square root and the 31-stage divider
// whole pipeline advances together; a held output word freezes every stage
// rst_n clears the valid bits and side-band words, arithmetic registers run free
module ghost_point_line_reflection
    import gplr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  first_x,
    input  logic signed [31:0]  first_y,
    input  logic signed [31:0]  second_x,
    input  logic signed [31:0]  second_y,
    input  logic signed [31:0]  centre_x,
    input  logic signed [31:0]  centre_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  foot_x,
    output logic signed [31:0]  foot_y,
    output logic signed [31:0]  mirror_x,
    output logic signed [31:0]  mirror_y,
    output logic signed [17:0]  normal_x,
    output logic signed [17:0]  normal_y,
    output logic                degenerate
);

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: direction and magnitudes
    logic signed [32:0] dx, dy;
    side_t              s1_next, s1_reg;
    assign dx = {first_x[31], first_x} - {second_x[31], second_x};
    assign dy = {first_y[31], first_y} - {second_y[31], second_y};

    always_comb
    begin
        s1_next.valid = in_valid;
        s1_next.deg   = (dx == '0) && (dy == '0);
        s1_next.sx    = dx[32];
        s1_next.sy    = dy[32];
        s1_next.mx    = dx[32] ? 32'(-dx) : dx[31:0];
        s1_next.my    = dy[32] ? 32'(-dy) : dy[31:0];
        s1_next.x1    = first_x;
        s1_next.y1    = first_y;
        s1_next.cx    = centre_x;
        s1_next.cy    = centre_y;
    end

    // stage 2: squares, stage 3: sum of squares
    side_t       s2_reg, s3_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic [64:0] nsum_reg;

    // side line spans the root, numerator and divider stages
    side_t             line_reg [0:LINE_LEN-1];
    logic [ROOT_W-1:0] root;
    logic [NUM_W-1:0]  numx_reg, numy_reg;
    logic [ROOT_W-1:0] len_reg;
    logic [QUO_W-1:0]  qx, qy;

    gplr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  ({1'b0, nsum_reg}),
        .root (root)
    );

    gplr_div u_divx (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (len_reg),
        .quo (qx)
    );

    gplr_div u_divy (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (len_reg),
        .quo (qy)
    );

    // unit direction and centre offset
    side_t              st_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic signed [32:0] ex_reg, ey_reg;
    // products
    side_t              sp_reg;
    logic signed [31:0] ptx_reg, pty_reg;
    logic signed [64:0] p1_reg, p2_reg, p3_reg, p4_reg;
    // dot and cross
    side_t              sa_reg;
    logic signed [31:0] atx_reg, aty_reg;
    logic signed [65:0] alpha_reg, beta_reg;
    // rounded projections and normal
    side_t              sr_reg;
    logic signed [31:0] rtx_reg, rty_reg, rny0_reg;
    logic signed [36:0] a_reg, b_reg;
    logic signed [17:0] nx_reg, ny_reg;
    // second products
    side_t              sm_reg;
    logic signed [68:0] mfx_reg, mfy_reg, mmx_reg, mmy_reg;
    logic signed [17:0] mnx_reg, mny_reg;

    logic signed [66:0] alpha_rnd, beta_rnd;
    logic signed [32:0] nsel, nxr, nyr;
    logic               beta_pos;
    assign alpha_rnd = {alpha_reg[65], alpha_reg} + 67'sd536870912;
    assign beta_rnd  = {beta_reg[65], beta_reg} + 67'sd536870912;
    assign beta_pos  = !beta_reg[65] && (beta_reg != '0);
    // normal points towards the centre's side
    assign nsel      = beta_pos ? -{aty_reg[31], aty_reg} : {aty_reg[31], aty_reg};
    assign nxr       = nsel + 33'sd8192;
    assign nyr       = (beta_pos ? {atx_reg[31], atx_reg} : -{atx_reg[31], atx_reg})
                       + 33'sd8192;

    logic signed [69:0] fx_rnd, fy_rnd, gx_rnd, gy_rnd;
    logic signed [41:0] fx_sum, fy_sum, gx_sum, gy_sum;
    assign fx_rnd = {mfx_reg[68], mfx_reg} + 70'sd536870912;
    assign fy_rnd = {mfy_reg[68], mfy_reg} + 70'sd536870912;
    assign gx_rnd = {mmx_reg[68], mmx_reg} + 70'sd268435456;
    assign gy_rnd = {mmy_reg[68], mmy_reg} + 70'sd268435456;
    assign fx_sum = 42'($signed(fx_rnd[69:30])) + 42'(sm_reg.x1);
    assign fy_sum = 42'($signed(fy_rnd[69:30])) + 42'(sm_reg.y1);
    assign gx_sum = 42'($signed(gx_rnd[69:29])) + 42'(sm_reg.cx);
    assign gy_sum = 42'($signed(gy_rnd[69:29])) + 42'(sm_reg.cy);

    side_t last_side;
    logic  out_valid_reg;
    assign last_side = line_reg[LINE_LEN-1];

    // side-band words and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            for (int i = 0; i < LINE_LEN; i++)
                line_reg[i] <= '0;
            st_reg        <= '0;
            sp_reg        <= '0;
            sa_reg        <= '0;
            sr_reg        <= '0;
            sm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            line_reg[0] <= s3_reg;
            for (int i = 1; i < LINE_LEN; i++)
                line_reg[i] <= line_reg[i-1];
            st_reg        <= last_side;
            sp_reg        <= st_reg;
            sa_reg        <= sp_reg;
            sr_reg        <= sa_reg;
            sm_reg        <= sr_reg;
            out_valid_reg <= sm_reg.valid;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= 64'(s1_reg.mx) * 64'(s1_reg.mx);
            sqy_reg  <= 64'(s1_reg.my) * 64'(s1_reg.my);
            nsum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};

            // numerator with half the length for rounding
            numx_reg <= {1'b0, line_reg[SQRT_LAT-1].mx, 30'b0} + {31'b0, root[ROOT_W-1:1]};
            numy_reg <= {1'b0, line_reg[SQRT_LAT-1].my, 30'b0} + {31'b0, root[ROOT_W-1:1]};
            len_reg  <= root;

            tx_reg <= last_side.sx ? -{1'b0, qx} : {1'b0, qx};
            ty_reg <= last_side.sy ? -{1'b0, qy} : {1'b0, qy};
            ex_reg <= {last_side.cx[31], last_side.cx} - {last_side.x1[31], last_side.x1};
            ey_reg <= {last_side.cy[31], last_side.cy} - {last_side.y1[31], last_side.y1};

            ptx_reg <= tx_reg;
            pty_reg <= ty_reg;
            p1_reg  <= 65'(tx_reg) * 65'(ex_reg);
            p2_reg  <= 65'(ty_reg) * 65'(ey_reg);
            p3_reg  <= 65'(tx_reg) * 65'(ey_reg);
            p4_reg  <= 65'(ty_reg) * 65'(ex_reg);

            atx_reg   <= ptx_reg;
            aty_reg   <= pty_reg;
            alpha_reg <= {p1_reg[64], p1_reg} + {p2_reg[64], p2_reg};
            beta_reg  <= {p3_reg[64], p3_reg} - {p4_reg[64], p4_reg};

            rtx_reg  <= atx_reg;
            rty_reg  <= aty_reg;
            rny0_reg <= -atx_reg;
            a_reg    <= alpha_rnd[66:30];
            b_reg    <= beta_rnd[66:30];
            nx_reg   <= nxr[31:14];
            ny_reg   <= nyr[31:14];

            mfx_reg <= 69'(a_reg) * 69'(rtx_reg);
            mfy_reg <= 69'(a_reg) * 69'(rty_reg);
            mmx_reg <= 69'(b_reg) * 69'(rty_reg);
            mmy_reg <= 69'(b_reg) * 69'(rny0_reg);
            mnx_reg <= nx_reg;
            mny_reg <= ny_reg;

            // output word, zeroed for a zero-length segment
            degenerate <= sm_reg.deg;
            foot_x     <= sm_reg.deg ? '0 : sat32(fx_sum);
            foot_y     <= sm_reg.deg ? '0 : sat32(fy_sum);
            mirror_x   <= sm_reg.deg ? '0 : sat32(gx_sum);
            mirror_y   <= sm_reg.deg ? '0 : sat32(gy_sum);
            normal_x   <= sm_reg.deg ? '0 : mnx_reg;
            normal_y   <= sm_reg.deg ? '0 : mny_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> foot_x == '0 && mirror_y == '0 && normal_x == '0)
        else $error("degenerate word not zeroed");
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            normal_x <= 18'sd65536 && normal_x >= -18'sd65536 &&
            normal_y <= 18'sd65536 && normal_y >= -18'sd65536)
        else $error("normal out of range");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline frozen");
`endif

endmodule

>>> sim/tb_top.sv
// testbench for the ghost point line reflection block: directed and random segment queries
module tb_top;

    // a single expected output word
    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic               deg;
    } reflect_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] mirror_x;
    logic signed [31:0] mirror_y;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic               degenerate;

    reflect_t pending_q[$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       n_degen;
    int       n_sat;
    int       burst_left;
    int       stall_mode;

    ghost_point_line_reflection u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .foot_x     (foot_x),
        .foot_y     (foot_y),
        .mirror_x   (mirror_x),
        .mirror_y   (mirror_y),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .degenerate (degenerate)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // floor((v + 2^(k-1)) / 2^k): arithmetic shift floors for signed values
    function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] v, input int k);
        logic signed [127:0] t;
        t = v + (128'sd1 <<< (k - 1));
        return t >>> k;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor square root of a 66-bit radicand, bit by bit from the top
    function automatic logic [32:0] floor_root(input logic [127:0] r);
        logic [127:0] acc;
        logic [127:0] c;
        acc = 0;
        for (int b = 32; b >= 0; b--)
        begin
            c = acc | (128'd1 << b);
            if (c * c <= r)
                acc = c;
        end
        return acc[32:0];
    endfunction

    // unit component in Q2.30, rounded half away from zero
    function automatic logic signed [127:0] unit_q30(input logic signed [127:0] d,
                                                     input logic [127:0] len);
        logic [127:0] m;
        logic [127:0] q;
        m = (d < 0) ? -d : d;
        q = ((m << 30) + (len >> 1)) / len;
        return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic reflect_t predict_reflection(
        input logic signed [31:0] x1, input logic signed [31:0] y1,
        input logic signed [31:0] x2, input logic signed [31:0] y2,
        input logic signed [31:0] cx, input logic signed [31:0] cy);
        reflect_t            r;
        logic signed [127:0] dx, dy, tx, ty, ex, ey, al, be, a, b, nx, ny, fx, fy, mx, my;
        logic [127:0]        len;
        dx = 128'(x1) - 128'(x2);
        dy = 128'(y1) - 128'(y2);
        r = '{default: 0};
        if (dx == 0 && dy == 0)
        begin
            r.deg = 1'b1;
            return r;
        end
        len = 128'(floor_root(dx * dx + dy * dy));
        tx = unit_q30(dx, len);
        ty = unit_q30(dy, len);
        ex = 128'(cx) - 128'(x1);
        ey = 128'(cy) - 128'(y1);
        al = tx * ex + ty * ey;
        be = tx * ey - ty * ex;
        a  = rnd_shift(al, 30);
        b  = rnd_shift(be, 30);
        fx = 128'(x1) + rnd_shift(a * tx, 30);
        fy = 128'(y1) + rnd_shift(a * ty, 30);
        mx = 128'(cx) + rnd_shift(b * ty, 29);
        my = 128'(cy) + rnd_shift(-b * tx, 29);
        nx = (be > 0) ? -ty : ty;
        ny = (be > 0) ? tx : -tx;
        r.fx = clip32(fx);
        r.fy = clip32(fy);
        r.mx = clip32(mx);
        r.my = clip32(my);
        r.nx = 18'(rnd_shift(nx, 14));
        r.ny = 18'(rnd_shift(ny, 14));
        if (r.fx !== fx[31:0] || r.fy !== fy[31:0] || r.mx !== mx[31:0] || r.my !== my[31:0])
            n_sat++;
        return r;
    endfunction

    // send one query word, holding valid across back-to-back words of a burst
    task automatic send_query(input logic signed [31:0] x1, input logic signed [31:0] y1,
                              input logic signed [31:0] x2, input logic signed [31:0] y2,
                              input logic signed [31:0] cx, input logic signed [31:0] cy);
        reflect_t e;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        first_x  <= x1;
        first_y  <= y1;
        second_x <= x2;
        second_y <= y2;
        centre_x <= cx;
        centre_y <= cy;
        in_valid <= 1'b1;
        e = predict_reflection(x1, y1, x2, y2, cx, cy);
        if (e.deg)
            n_degen++;
        // expectation queued before acceptance is fine: outputs emerge only after the full pipeline
        pending_q.push_back(e);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        n_sent++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            2: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
            default: return $signed($urandom_range(0, 2047)) - 32'sd1024;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        lo = 32'sh80000000;
        hi = 32'sh7fffffff;
        // degenerate segments
        send_query(0, 0, 0, 0, 0, 0);
        send_query(hi, lo, hi, lo, 12345, -7);
        send_query(lo, lo, lo, lo, hi, hi);
        // axis-aligned and diagonal, centre on either side and on the line
        send_query(0, 0, 32'sh10000, 0, 32'sh8000, 32'sh20000);
        send_query(0, 0, 32'sh10000, 0, 32'sh8000, -32'sh20000);
        send_query(0, 0, 0, 32'sh10000, 32'sh30000, 5);
        send_query(0, 0, 32'sh10000, 0, 32'sh50000, 0);
        send_query(32'sh10000, 32'sh10000, -32'sh10000, -32'sh10000, 32'sh20000, 32'sh20000);
        // widest segments, short segments and saturating mirrors
        send_query(hi, hi, lo, lo, lo, hi);
        send_query(lo, hi, hi, lo, hi, hi);
        send_query(lo, 0, hi, 0, 0, hi);
        send_query(0, lo, 0, hi, hi, 0);
        send_query(hi, 0, lo, 0, lo, lo);
        send_query(0, 0, 1, 0, 0, hi);
        send_query(0, 0, 0, 1, lo, 0);
        send_query(1, 1, 0, 0, hi, lo);
        send_query(-1, 0, 0, 1, -1, -1);
        send_query(hi, hi, hi, lo, 32'sh7ffffff0, lo);
        send_query(32'sh00030000, 32'sh00040000, 0, 0, -32'sh00050000, 32'sh00020000);
    endtask

    task automatic test_random_queries();
        logic signed [31:0] x1, y1, x2, y2;
        for (int i = 0; i < 1630; i++)
        begin
            x1 = rand_coord();
            y1 = rand_coord();
            x2 = rand_coord();
            y2 = rand_coord();
            // some degenerate and near-degenerate segments
            if ($urandom_range(0, 39) == 0)
            begin
                x2 = x1;
                y2 = y1;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                x2 = x1 + $signed($urandom_range(0, 2)) - 1;
                y2 = y1 + 1;
            end
            send_query(x1, y1, x2, y2, rand_coord(), rand_coord());
        end
        in_valid <= 1'b0;
    endtask

    // receiver stall pattern: mode changes now and then, including never stalling
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // result checker: compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        reflect_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected output word: foot %0d,%0d", foot_x, foot_y);
            end
            else
            begin
                e = pending_q.pop_front();
                n_checked++;
                if (foot_x !== e.fx || foot_y !== e.fy || mirror_x !== e.mx
                    || mirror_y !== e.my || normal_x !== e.nx || normal_y !== e.ny
                    || degenerate !== e.deg)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("mismatch word %0d: exp foot %0d,%0d mir %0d,%0d nrm %0d,%0d deg %0b",
                                 n_checked, e.fx, e.fy, e.mx, e.my, e.nx, e.ny, e.deg);
                        $display("                 got foot %0d,%0d mir %0d,%0d nrm %0d,%0d deg %0b",
                                 foot_x, foot_y, mirror_x, mirror_y, normal_x, normal_y,
                                 degenerate);
                    end
                end
            end
        end
    end

    // watchdog: 1649 words, each at worst a long stall plus pipeline latency
    initial
    begin
        #(20 * 400000);
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        n_errors   = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_degen    = 0;
        n_sat      = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        first_x    = 0;
        first_y    = 0;
        second_x   = 0;
        second_y   = 0;
        centre_x   = 0;
        centre_y   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_random_queries();
        // drain, then allow the pipeline latency for stray words
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        $display("sent %0d query words, checked %0d results", n_sent, n_checked);
        $display("covered %0d zero-length segments and %0d saturating results", n_degen, n_sat);
        if (n_errors == 0 && pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/gplr_pkg.sv
hw/rtl/gplr_sqrt.sv
hw/rtl/gplr_div.sv
hw/rtl/ghost_point_line_reflection.sv
sim/tb_top.sv
